### rtl/tfvk_pkg.sv
package tfvk_pkg;

  localparam int unsigned NUM_KEYS_DEF = 4;
  localparam int unsigned NUM_KEYS_MAX = 8;
  localparam int unsigned KEY_IDX_W    = $clog2(NUM_KEYS_MAX);

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned POS_W      = 16;

  localparam logic [11:0] X_MAX_RST           = 12'd1514;
  localparam logic [11:0] Y_MAX_RST           = 12'd2558;
  localparam logic [7:0]  MOVE_THRESHOLD_RST  = 8'd18;
  localparam logic [11:0] STRIP_HEIGHT_RST    = 12'd300;
  localparam logic [9:0]  KEY_HALF_WIDTH_RST  = 10'd160;
  localparam logic [9:0]  KEY_HALF_HEIGHT_RST = 10'd150;
  localparam logic [9:0]  DEBOUNCE_TICKS_RST  = 10'd80;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_MAX           = 3'd0,
    CFG_Y_MAX           = 3'd1,
    CFG_MOVE_THRESHOLD  = 3'd2,
    CFG_STRIP_HEIGHT    = 3'd3,
    CFG_KEY_HALF_WIDTH  = 3'd4,
    CFG_KEY_HALF_HEIGHT = 3'd5,
    CFG_DEBOUNCE_TICKS  = 3'd6
  } cfg_idx_t;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_TICK   = 1'b1
  } req_type_t;

  typedef enum logic {
    REPORT_PEN = 1'b0,
    REPORT_KEY = 1'b1
  } report_kind_t;

  typedef struct packed {
    logic [11:0] x_max;
    logic [11:0] y_max;
    logic [7:0]  move_threshold;
    logic [11:0] strip_height;
    logic [9:0]  key_half_width;
    logic [9:0]  key_half_height;
    logic [9:0]  debounce_ticks;
  } cfg_t;

  typedef struct packed {
    logic                 in_strip;
    logic                 key_hit;
    logic [KEY_IDX_W-1:0] key_idx;
  } hit_t;

  typedef struct packed {
    logic             report_kind;
    logic [POS_W-1:0] pen_x;
    logic [POS_W-1:0] pen_y;
    logic [7:0]       pen_pressure;
    logic             pen_down;
    logic [1:0]       key_index;
    logic             key_pressed;
  } result_t;

endpackage

### rtl/tfvk_if.sv
interface tfvk_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] x_high;
  logic [7:0] y_high;
  logic [7:0] xy_low;
  logic [7:0] pressure;

  modport source (output valid, output req_type, output x_high, output y_high,
                  output xy_low, output pressure, input ready);
  modport sink   (input valid, input req_type, input x_high, input y_high,
                  input xy_low, input pressure, output ready);
endinterface

interface tfvk_out_if;
  logic        valid;
  logic        ready;
  logic        report_kind;
  logic [15:0] pen_x;
  logic [15:0] pen_y;
  logic [7:0]  pen_pressure;
  logic        pen_down;
  logic [1:0]  key_index;
  logic        key_pressed;

  modport source (output valid, output report_kind, output pen_x, output pen_y,
                  output pen_pressure, output pen_down, output key_index,
                  output key_pressed, input ready);
  modport sink   (input valid, input report_kind, input pen_x, input pen_y,
                  input pen_pressure, input pen_down, input key_index,
                  input key_pressed, output ready);
endinterface

### rtl/tfvk_cfg.sv
module tfvk_cfg #(
  parameter int unsigned NUM_KEYS = tfvk_pkg::NUM_KEYS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [tfvk_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tfvk_pkg::CFG_DATA_W-1:0] cfg_data,
  output tfvk_pkg::cfg_t                  cfg,
  output logic [tfvk_pkg::COORD_W-1:0]    key_cx [NUM_KEYS]
);

  // Key center i is x_max*(2i+1)/(2*NUM_KEYS). The numerator is formed when
  // x_max is written, and the division is a multiply by a rounded-up
  // reciprocal, exact for any 16-bit numerator.
  localparam int unsigned DIV = 2 * NUM_KEYS;
  localparam int unsigned NUM_W = 16;
  localparam int unsigned SH = NUM_W + $clog2(DIV);
  localparam longint unsigned MUL = ((64'd1 << SH) + DIV - 1) / DIV;
  localparam int unsigned PW = SH + tfvk_pkg::COORD_W;

  tfvk_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_max           <= tfvk_pkg::X_MAX_RST;
      cfg_r.y_max           <= tfvk_pkg::Y_MAX_RST;
      cfg_r.move_threshold  <= tfvk_pkg::MOVE_THRESHOLD_RST;
      cfg_r.strip_height    <= tfvk_pkg::STRIP_HEIGHT_RST;
      cfg_r.key_half_width  <= tfvk_pkg::KEY_HALF_WIDTH_RST;
      cfg_r.key_half_height <= tfvk_pkg::KEY_HALF_HEIGHT_RST;
      cfg_r.debounce_ticks  <= tfvk_pkg::DEBOUNCE_TICKS_RST;
    end else if (cfg_we) begin
      unique case (tfvk_pkg::cfg_idx_t'(cfg_index))
        tfvk_pkg::CFG_X_MAX:           cfg_r.x_max           <= cfg_data;
        tfvk_pkg::CFG_Y_MAX:           cfg_r.y_max           <= cfg_data;
        tfvk_pkg::CFG_MOVE_THRESHOLD:  cfg_r.move_threshold  <= cfg_data[7:0];
        tfvk_pkg::CFG_STRIP_HEIGHT:    cfg_r.strip_height    <= cfg_data;
        tfvk_pkg::CFG_KEY_HALF_WIDTH:  cfg_r.key_half_width  <= cfg_data[9:0];
        tfvk_pkg::CFG_KEY_HALF_HEIGHT: cfg_r.key_half_height <= cfg_data[9:0];
        tfvk_pkg::CFG_DEBOUNCE_TICKS:  cfg_r.debounce_ticks  <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

  for (genvar i = 0; i < NUM_KEYS; i++) begin : g_center
    localparam int unsigned ODD = 2 * i + 1;
    localparam logic [NUM_W-1:0] V_RST = NUM_W'(tfvk_pkg::X_MAX_RST * ODD);
    localparam logic [tfvk_pkg::COORD_W-1:0] CX_RST =
      tfvk_pkg::COORD_W'((tfvk_pkg::X_MAX_RST * ODD) / DIV);

    logic [NUM_W-1:0]            num_r;
    logic [PW-1:0]               prod;
    logic [tfvk_pkg::COORD_W-1:0] cx_r;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        num_r <= V_RST;
      end else if (cfg_we && cfg_index == tfvk_pkg::CFG_X_MAX) begin
        num_r <= NUM_W'(cfg_data) * NUM_W'(ODD);
      end
    end

    assign prod = PW'(num_r) * PW'(MUL);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cx_r <= CX_RST;
      end else begin
        cx_r <= prod[SH +: tfvk_pkg::COORD_W];
      end
    end

    assign key_cx[i] = cx_r;
  end

endmodule

### rtl/tfvk_key_hit.sv
module tfvk_key_hit #(
  parameter int unsigned NUM_KEYS = tfvk_pkg::NUM_KEYS_DEF
) (
  input  tfvk_pkg::cfg_t               cfg,
  input  logic [tfvk_pkg::COORD_W-1:0] key_cx [NUM_KEYS],
  input  logic [tfvk_pkg::POS_W-1:0]   pt_x,
  input  logic [tfvk_pkg::POS_W-1:0]   pt_y,
  output tfvk_pkg::hit_t               hit
);

  // Geometry is signed so that a strip start or key center below zero
  // compares correctly against the never negative point.
  logic signed [17:0] px_s;
  logic signed [17:0] py_s;
  logic signed [17:0] strip_lo;
  logic signed [17:0] cy;
  logic signed [17:0] dy;
  logic signed [17:0] ady;
  logic               y_ok;
  logic [NUM_KEYS-1:0] x_ok;

  assign px_s     = $signed({2'b00, pt_x});
  assign py_s     = $signed({2'b00, pt_y});
  assign strip_lo = $signed({6'd0, cfg.y_max}) - $signed({6'd0, cfg.strip_height});
  assign cy       = $signed({6'd0, cfg.y_max}) - 18'sd2;
  assign dy       = py_s - cy;
  assign ady      = (dy < 0) ? -dy : dy;
  assign y_ok     = ady <= $signed({8'd0, cfg.key_half_height});

  for (genvar i = 0; i < NUM_KEYS; i++) begin : g_x
    logic signed [17:0] dx;
    logic signed [17:0] adx;
    assign dx      = px_s - $signed({6'd0, key_cx[i]});
    assign adx     = (dx < 0) ? -dx : dx;
    assign x_ok[i] = adx <= $signed({8'd0, cfg.key_half_width});
  end

  always_comb begin
    hit.in_strip = (pt_x <= {4'd0, cfg.x_max}) && (py_s >= strip_lo) &&
                   (pt_y <= {4'd0, cfg.y_max});
    hit.key_hit  = 1'b0;
    hit.key_idx  = '0;
    // Walk down so the lowest matching key is the one left standing.
    for (int i = NUM_KEYS - 1; i >= 0; i--) begin
      if (x_ok[i] && y_ok) begin
        hit.key_hit = 1'b1;
        hit.key_idx = tfvk_pkg::KEY_IDX_W'(i);
      end
    end
  end

endmodule

### rtl/tfvk_core.sv
module tfvk_core #(
  parameter int unsigned NUM_KEYS = tfvk_pkg::NUM_KEYS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  tfvk_in_if.sink                      in_ch,
  tfvk_out_if.source                   out_ch,
  input  tfvk_pkg::cfg_t               cfg,
  input  logic [tfvk_pkg::COORD_W-1:0] key_cx [NUM_KEYS]
);

  localparam int unsigned PW = tfvk_pkg::POS_W;
  localparam int unsigned KW = tfvk_pkg::KEY_IDX_W;

  // Input register.
  logic       in_valid_r;
  logic       in_type_r;
  logic [7:0] in_xh_r;
  logic [7:0] in_yh_r;
  logic [7:0] in_lo_r;
  logic [7:0] in_p_r;

  // Tracking state.
  logic [PW-1:0] last_x_r, last_x_nxt;
  logic [PW-1:0] last_y_r, last_y_nxt;
  logic          first_r, first_nxt;
  logic          held_valid_r, held_valid_nxt;
  logic [KW-1:0] held_r, held_nxt;
  logic          released_r, released_nxt;
  logic          press_sent_r, press_sent_nxt;
  logic          area_first_r, area_first_nxt;
  logic [9:0]    count_r, count_nxt;

  // Result register.
  logic              out_valid_r;
  tfvk_pkg::result_t out_r;
  tfvk_pkg::result_t res;
  logic              res_valid;

  logic                      advance;
  logic                      is_tick;
  logic                      pressed;
  logic [tfvk_pkg::COORD_W-1:0] raw_x;
  logic [tfvk_pkg::COORD_W-1:0] raw_y;
  logic [PW-1:0]             px;
  logic [PW-1:0]             py;
  logic [PW-1:0]             dx;
  logic [PW-1:0]             dy;
  logic                      moved;
  logic [PW-1:0]             pt_x;
  logic [PW-1:0]             pt_y;
  tfvk_pkg::hit_t            hit;

  // The stage moves on whenever the result register is free or being drained.
  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_type_r <= in_ch.req_type;
      in_xh_r   <= in_ch.x_high;
      in_yh_r   <= in_ch.y_high;
      in_lo_r   <= in_ch.xy_low;
      in_p_r    <= in_ch.pressure;
    end
  end

  assign is_tick = in_type_r == tfvk_pkg::REQ_TICK;
  assign pressed = in_p_r != 8'd0;
  assign raw_x   = {in_xh_r, in_lo_r[3:0]};
  assign raw_y   = {in_yh_r, in_lo_r[7:4]};
  assign px      = {4'd0, cfg.x_max} - {4'd0, raw_x};
  assign py      = {4'd0, cfg.y_max} - {4'd0, raw_y};
  assign dx      = (last_x_r > px) ? last_x_r - px : px - last_x_r;
  assign dy      = (last_y_r > py) ? last_y_r - py : py - last_y_r;
  assign moved   = (dx > {8'd0, cfg.move_threshold}) || (dy > {8'd0, cfg.move_threshold});

  // A press is tested at the new point; a release or a tick at the last one.
  assign pt_x = (!is_tick && pressed) ? px : last_x_r;
  assign pt_y = (!is_tick && pressed) ? py : last_y_r;

  tfvk_key_hit #(
    .NUM_KEYS (NUM_KEYS)
  ) u_key_hit (
    .cfg    (cfg),
    .key_cx (key_cx),
    .pt_x   (pt_x),
    .pt_y   (pt_y),
    .hit    (hit)
  );

  always_comb begin
    last_x_nxt     = last_x_r;
    last_y_nxt     = last_y_r;
    first_nxt      = first_r;
    held_valid_nxt = held_valid_r;
    held_nxt       = held_r;
    released_nxt   = released_r;
    press_sent_nxt = press_sent_r;
    area_first_nxt = area_first_r;
    count_nxt      = count_r;
    res_valid      = 1'b0;
    res            = '0;

    if (advance) begin
      if (is_tick) begin
        if (count_r != 10'd0) begin
          count_nxt = count_r - 10'd1;
          if (count_r == 10'd1) begin
            if (hit.key_hit && held_valid_r && hit.key_idx == held_r) begin
              released_nxt    = 1'b0;
              press_sent_nxt  = 1'b1;
              res_valid       = 1'b1;
              res.report_kind = tfvk_pkg::REPORT_KEY;
              res.key_index   = held_r[1:0];
              res.key_pressed = 1'b1;
            end else begin
              released_nxt   = 1'b1;
              held_valid_nxt = 1'b0;
              held_nxt       = '0;
              press_sent_nxt = 1'b0;
            end
          end
        end
      end else if (pressed) begin
        if (first_r || moved) begin
          first_nxt  = 1'b0;
          last_x_nxt = px;
          last_y_nxt = py;
          if (hit.in_strip) begin
            // Touches in the strip only arm the debounce; they never report.
            if (!((!released_r && held_valid_r) || area_first_r) && hit.key_hit) begin
              held_nxt       = hit.key_idx;
              held_valid_nxt = 1'b1;
              released_nxt   = 1'b0;
              press_sent_nxt = 1'b0;
              count_nxt      = (cfg.debounce_ticks == 10'd0) ? 10'd1 : cfg.debounce_ticks;
            end
          end else begin
            area_first_nxt   = 1'b1;
            res_valid        = 1'b1;
            res.report_kind  = tfvk_pkg::REPORT_PEN;
            res.pen_x        = px;
            res.pen_y        = py;
            res.pen_pressure = in_p_r;
            res.pen_down     = 1'b1;
          end
        end
      end else begin
        first_nxt      = 1'b1;
        area_first_nxt = 1'b0;
        res_valid      = 1'b1;
        if (hit.in_strip) begin
          count_nxt = 10'd0;
          if (held_valid_r && !released_r && press_sent_r) begin
            res.report_kind = tfvk_pkg::REPORT_KEY;
            res.key_index   = held_r[1:0];
            res.key_pressed = 1'b0;
          end
          released_nxt   = 1'b0;
          held_valid_nxt = 1'b0;
          held_nxt       = '0;
          press_sent_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_x_r     <= '0;
      last_y_r     <= '0;
      first_r      <= 1'b1;
      held_valid_r <= 1'b0;
      held_r       <= '0;
      released_r   <= 1'b1;
      press_sent_r <= 1'b1;
      area_first_r <= 1'b0;
      count_r      <= '0;
    end else begin
      last_x_r     <= last_x_nxt;
      last_y_r     <= last_y_nxt;
      first_r      <= first_nxt;
      held_valid_r <= held_valid_nxt;
      held_r       <= held_nxt;
      released_r   <= released_nxt;
      press_sent_r <= press_sent_nxt;
      area_first_r <= area_first_nxt;
      count_r      <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.report_kind  = out_r.report_kind;
  assign out_ch.pen_x        = out_r.pen_x;
  assign out_ch.pen_y        = out_r.pen_y;
  assign out_ch.pen_pressure = out_r.pen_pressure;
  assign out_ch.pen_down     = out_r.pen_down;
  assign out_ch.key_index    = out_r.key_index;
  assign out_ch.key_pressed  = out_r.key_pressed;

endmodule

### rtl/touch_filter_virtual_keys.sv
// Touch panel front end with virtual keys along the bottom edge.
// in_ch carries touch samples and 1 ms ticks (req_type selects which); out_ch
// carries pen reports and key press/release reports. An item is transferred
// when valid and ready are both high. Each input gives zero or one result.
// An item waits in the input register until the stage advances, and its
// result is then registered. Throughput: one item per cycle while out_ch
// takes results, set by the single input register to result register pass;
// the mirror, move test and key box compares all sit in that pass.
// The cfg_* port writes one register per cycle with cfg_we high; the user
// must have it written only while no item is in flight; nothing enforces it.
// A new x_max reaches the key centers through a registered reciprocal multiply.
// Reset (rst_n low, synchronous) restores the register defaults, clears the
// tracking state and empties both the input and output registers.
// When out_ch stalls the result is held; one more item can be taken into the
// input register, after which in_ch.ready stays low until the result leaves.
module touch_filter_virtual_keys #(
  parameter int unsigned NUM_KEYS = tfvk_pkg::NUM_KEYS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  tfvk_in_if.sink                         in_ch,
  tfvk_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [tfvk_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tfvk_pkg::CFG_DATA_W-1:0] cfg_data
);

  tfvk_pkg::cfg_t               cfg;
  logic [tfvk_pkg::COORD_W-1:0] key_cx [NUM_KEYS];

  tfvk_cfg #(
    .NUM_KEYS (NUM_KEYS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .key_cx    (key_cx)
  );

  tfvk_core #(
    .NUM_KEYS (NUM_KEYS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg),
    .key_cx (key_cx)
  );

endmodule

### rtl/tfvk_chk.sv
module tfvk_chk (
  input logic         clk,
  input logic         rst_n,
  tfvk_in_if.sink     in_ch,
  tfvk_out_if.source  out_ch
);

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=>
      out_ch.valid && $stable(out_ch.report_kind) && $stable(out_ch.pen_x) &&
      $stable(out_ch.pen_y) && $stable(out_ch.pen_pressure) &&
      $stable(out_ch.key_index) && $stable(out_ch.key_pressed))
    else $error("stalled result changed");

  // With the result register empty, the input stage can always move on.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with an empty result register");

  a_pen_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.report_kind == tfvk_pkg::REPORT_PEN |->
      out_ch.key_index == 2'd0 && !out_ch.key_pressed &&
      (out_ch.pen_down == (out_ch.pen_pressure != 8'd0)) &&
      (out_ch.pen_down || (out_ch.pen_x == 16'd0 && out_ch.pen_y == 16'd0)))
    else $error("inconsistent pen report");

  a_key_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.report_kind == tfvk_pkg::REPORT_KEY |->
      out_ch.pen_x == 16'd0 && out_ch.pen_y == 16'd0 &&
      out_ch.pen_pressure == 8'd0 && !out_ch.pen_down)
    else $error("key report carries pen data");

endmodule

bind touch_filter_virtual_keys tfvk_chk u_chk (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);
